[rtl/core/irt_pkg.sv]
// Shared types and constants for the INI record tokenizer.
// Holds the byte-transfer and result-transfer payloads, record kinds and
// character codes. Depends on nothing.
package irt_pkg;

	// Default width of the byte position counters
	localparam int unsigned POSITION_BITS_DEF = 16;

	// Depth of the result queue (power of two, at least two)
	localparam int unsigned RES_DEPTH = 4;

	// Saturation limits of the 16-bit result fields and the line counter
	localparam logic [15:0] FIELD_MAX = 16'hFFFF;
	localparam logic [15:0] LINE_MAX  = 16'hFFFF;

	// Character codes
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;

	// Record kinds
	typedef enum logic [2:0] {
		KIND_SECTION = 3'd0,
		KIND_COMMENT = 3'd1,
		KIND_VALUE   = 3'd2,
		KIND_ERROR   = 3'd3,
		KIND_END     = 3'd4
	} irt_kind_t;

	// One source byte transfer
	typedef struct packed {
		logic [7:0] source_byte;
		logic       is_final;
	} irt_src_t;

	// One result transfer
	typedef struct packed {
		irt_kind_t   record_kind;
		logic [15:0] name_offset;
		logic [15:0] name_length;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [15:0] line_number;
		logic        overflow_seen;
		logic        run_last;
	} irt_res_t;

	// Queue write requests from the scanner for one byte
	typedef struct packed {
		logic rec;
		logic fin;
	} irt_push_t;

endpackage

[rtl/core/ini_record_tokenizer.sv]
// Top level of the INI record tokenizer: input register, scanner, result queue.
// Depends on irt_pkg, irt_scan and irt_res_fifo.
//
// Source bytes are taken one per clock while the result queue has room, and each
// byte is scanned from its input register stage. A record is written to the result
// queue when the byte that closes it is scanned, and is offered on the result side
// from the clock edge after that. Most bytes give no result, a closing byte gives
// one, and the final byte gives up to two (the open record, then END), which leave
// one per clock through a four-entry result queue while the result side is ready.
// The scanner accepts a byte whenever that queue has room for two results, so with
// the result side taking one result per clock the sustained rate is one byte per
// clock. After the final byte all counters return to their reset values.
module ini_record_tokenizer #(
	parameter int unsigned POSITION_BITS = irt_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  irt_pkg::irt_src_t src_item,
	output logic              res_valid,
	input  logic              res_ready,
	output irt_pkg::irt_res_t res_item
);

	logic               valid_s1;
	irt_pkg::irt_src_t  src_s1;
	logic               fire, room;
	irt_pkg::irt_res_t  rec_res, end_res;
	irt_pkg::irt_push_t push;

	assign fire      = valid_s1 & room;
	assign src_ready = ~valid_s1 | fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && src_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			src_s1 <= src_item;
	end

	irt_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.src     (src_s1),
		.rec_res (rec_res),
		.end_res (end_res),
		.push    (push)
	);

	irt_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_res   (rec_res),
		.end_res   (end_res),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// a queued result is visible the cycle after it is written
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.rec || push.fin) |=> res_valid)
		else $error("result written but queue shows nothing");

	// END is always the last result of its byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.record_kind == irt_pkg::KIND_END) |-> res_item.run_last)
		else $error("END result not marked last");

	// line numbers start at one and never wrap to zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.line_number != 16'd0))
		else $error("result carries line number zero");

endmodule

[rtl/core/irt_scan.sv]
// Scanner state and combinational step logic of the INI record tokenizer.
// Takes the registered source byte, forms up to one record and an end result.
// Depends on irt_pkg.
module irt_scan #(
	parameter int unsigned POSITION_BITS = irt_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  irt_pkg::irt_src_t src,
	output irt_pkg::irt_res_t rec_res,
	output irt_pkg::irt_res_t end_res,
	output irt_pkg::irt_push_t push
);

	localparam int unsigned LW = POSITION_BITS + 1;
	localparam int unsigned CW = (LW > 17) ? LW : 17;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LW-1:0]            len_t;

	localparam pos_t POS_MAX = '1;

	typedef enum logic [2:0] {
		M_BETWEEN    = 3'd0,
		M_SECT_FIRST = 3'd1,
		M_SECT_NAME  = 3'd2,
		M_COMMENT    = 3'd3,
		M_KEY        = 3'd4,
		M_KEY_ESC    = 3'd5,
		M_VALUE_SKIP = 3'd6,
		M_VALUE      = 3'd7
	} mode_t;

	// a - b, or zero when b is not below a
	function automatic len_t span(input pos_t a, input pos_t b);
		return (a > b) ? (len_t'(a) - len_t'(b)) : '0;
	endfunction

	// trimmed value length of an entry closed at position e
	function automatic len_t run_len(input pos_t e, input pos_t vs, input pos_t ln);
		return (e > vs && ln >= vs) ? (len_t'(ln) + len_t'(1) - len_t'(vs)) : '0;
	endfunction

	function automatic logic too_big(input len_t v);
		return CW'(v) > CW'(irt_pkg::FIELD_MAX);
	endfunction

	function automatic logic [15:0] clamp(input len_t v);
		return too_big(v) ? irt_pkg::FIELD_MAX : 16'(CW'(v));
	endfunction

	mode_t       mode_q;
	pos_t        pos_q, rs_q, vs_q, ln_q;
	len_t        kl_q;
	logic [15:0] line_q;
	logic        sat_q;

	mode_t       m;
	pos_t        rs, vs, ln, end_v;
	len_t        kl;
	logic [15:0] line;
	logic        sat, sat_fin;
	logic        sect, fe, bt, named, blank, nl, cl;
	logic [7:0]  b;

	logic             r_have;
	irt_pkg::irt_kind_t r_kind;
	len_t             r_noff, r_nlen, r_voff, r_vlen;
	logic [15:0]      r_line;
	logic             r_sat;

	// one scan step, written in source order so flags and counts follow it
	always_comb begin
		b     = src.source_byte;
		blank = (b <= irt_pkg::CH_SPACE);
		nl    = (b == irt_pkg::CH_NEWLINE);
		m     = mode_q;
		rs    = rs_q;
		vs    = vs_q;
		ln    = ln_q;
		kl    = kl_q;
		line  = line_q;
		sat   = sat_q;
		end_v = pos_q;
		sect  = 1'b0;
		fe    = 1'b0;
		bt    = 1'b0;
		named = 1'b0;
		r_have = 1'b0;
		r_kind = irt_pkg::KIND_ERROR;
		r_noff = '0;
		r_nlen = '0;
		r_voff = '0;
		r_vlen = '0;
		r_line = line_q;
		r_sat  = sat_q;

		case (mode_q)
			M_SECT_FIRST, M_SECT_NAME: begin
				sect = (mode_q == M_SECT_NAME);
				if (mode_q == M_SECT_FIRST) begin
					if (blank) begin
						r_have = 1'b1;
						m  = M_BETWEEN;
						bt = 1'b1;
					end else begin
						rs   = pos_q;
						m    = M_SECT_NAME;
						sect = 1'b1;
					end
				end
				if (sect) begin
					if (b == irt_pkg::CH_RBRACKET) begin
						r_have = 1'b1;
						r_kind = irt_pkg::KIND_SECTION;
						r_noff = len_t'(rs);
						r_nlen = len_t'(pos_q - rs);
						m = M_BETWEEN;
					end else if (nl) begin
						r_have = 1'b1;
						m  = M_BETWEEN;
						bt = 1'b1;
					end
				end
			end
			M_COMMENT: begin
				if (nl) begin
					r_have = 1'b1;
					r_kind = irt_pkg::KIND_COMMENT;
					r_voff = len_t'(vs_q);
					r_vlen = span(pos_q, vs_q);
					m  = M_BETWEEN;
					bt = 1'b1;
				end
			end
			M_KEY: begin
				if (nl) begin
					fe = 1'b1;
					bt = 1'b1;
				end else if (b == irt_pkg::CH_BSLASH) begin
					ln = pos_q;
					m  = M_KEY_ESC;
				end else if (b == irt_pkg::CH_EQUALS || b == irt_pkg::CH_COLON) begin
					kl = len_t'(ln_q) + len_t'(1) - len_t'(rs_q);
					m  = M_VALUE_SKIP;
				end else if (!blank) begin
					ln = pos_q;
				end
			end
			M_KEY_ESC: begin
				if (!blank)
					ln = pos_q;
				m = M_KEY;
			end
			M_VALUE_SKIP: begin
				if (b != irt_pkg::CH_SPACE && b != irt_pkg::CH_TAB) begin
					vs = pos_q;
					ln = pos_q;
					m  = M_VALUE;
					if (nl) begin
						fe = 1'b1;
						bt = 1'b1;
					end
				end
			end
			M_VALUE: begin
				if (nl) begin
					fe = 1'b1;
					bt = 1'b1;
				end else if (!blank) begin
					ln = pos_q;
				end
			end
			default: begin
				m  = M_BETWEEN;
				bt = 1'b1;
			end
		endcase

		// entry closed by a newline
		if (fe) begin
			named  = (m == M_VALUE_SKIP || m == M_VALUE);
			r_have = 1'b1;
			r_kind = irt_pkg::KIND_VALUE;
			r_noff = named ? len_t'(rs) : '0;
			r_nlen = named ? kl : '0;
			r_voff = len_t'(vs);
			r_vlen = run_len(pos_q, vs, ln);
			m = M_BETWEEN;
		end

		// between records: skip blanks, count lines, open a record
		if (bt) begin
			if (blank) begin
				if (nl) begin
					if (line == irt_pkg::LINE_MAX)
						sat = 1'b1;
					else
						line = line + 16'd1;
				end
			end else begin
				rs = pos_q;
				if (b == irt_pkg::CH_LBRACKET) begin
					m = M_SECT_FIRST;
				end else if (b == irt_pkg::CH_HASH) begin
					if (pos_q == POS_MAX) begin
						vs  = POS_MAX;
						sat = 1'b1;
					end else begin
						vs = pos_q + pos_t'(1);
					end
					m = M_COMMENT;
				end else begin
					vs = pos_q;
					ln = pos_q;
					kl = '0;
					m  = M_KEY;
				end
			end
		end

		// end of source closes any open record
		fe = 1'b0;
		if (src.is_final) begin
			if (pos_q == POS_MAX) begin
				end_v = POS_MAX;
				sat   = 1'b1;
			end else begin
				end_v = pos_q + pos_t'(1);
			end
			case (m)
				M_SECT_FIRST, M_SECT_NAME: begin
					r_have = 1'b1;
					r_line = line;
					r_sat  = sat;
				end
				M_COMMENT: begin
					r_have = 1'b1;
					r_kind = irt_pkg::KIND_COMMENT;
					r_voff = len_t'(vs);
					r_vlen = span(end_v, vs);
					r_line = line;
					r_sat  = sat;
				end
				M_VALUE_SKIP: begin
					vs = end_v;
					fe = 1'b1;
				end
				M_KEY, M_KEY_ESC, M_VALUE: fe = 1'b1;
				default: ;
			endcase
			if (fe) begin
				named  = (m == M_VALUE_SKIP || m == M_VALUE);
				r_have = 1'b1;
				r_kind = irt_pkg::KIND_VALUE;
				r_noff = named ? len_t'(rs) : '0;
				r_nlen = named ? kl : '0;
				r_voff = len_t'(vs);
				r_vlen = run_len(end_v, vs, ln);
				r_line = line;
				r_sat  = sat;
			end
		end

		// field saturation feeds the sticky flag
		cl = too_big(r_noff) | too_big(r_nlen) | too_big(r_voff) | too_big(r_vlen);
		sat_fin = sat | (r_have & cl);
	end

	// result payloads
	always_comb begin
		rec_res.record_kind   = r_kind;
		rec_res.name_offset   = clamp(r_noff);
		rec_res.name_length   = clamp(r_nlen);
		rec_res.value_offset  = clamp(r_voff);
		rec_res.value_length  = clamp(r_vlen);
		rec_res.line_number   = r_line;
		rec_res.overflow_seen = r_sat | cl;
		rec_res.run_last      = ~src.is_final;

		end_res.record_kind   = irt_pkg::KIND_END;
		end_res.name_offset   = '0;
		end_res.name_length   = '0;
		end_res.value_offset  = '0;
		end_res.value_length  = '0;
		end_res.line_number   = line;
		end_res.overflow_seen = sat_fin;
		end_res.run_last      = 1'b1;

		push.rec = fire & r_have;
		push.fin = fire & src.is_final;
	end

	// scanner state; the final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BETWEEN;
			pos_q  <= '0;
			line_q <= 16'd1;
			rs_q   <= '0;
			kl_q   <= '0;
			vs_q   <= '0;
			ln_q   <= '0;
			sat_q  <= 1'b0;
		end else if (fire) begin
			if (src.is_final) begin
				mode_q <= M_BETWEEN;
				pos_q  <= '0;
				line_q <= 16'd1;
				rs_q   <= '0;
				kl_q   <= '0;
				vs_q   <= '0;
				ln_q   <= '0;
				sat_q  <= 1'b0;
			end else begin
				mode_q <= m;
				pos_q  <= (pos_q == POS_MAX) ? POS_MAX : (pos_q + pos_t'(1));
				line_q <= line;
				rs_q   <= rs;
				kl_q   <= kl;
				vs_q   <= vs;
				ln_q   <= ln;
				sat_q  <= sat_fin | (pos_q == POS_MAX);
			end
		end
	end

endmodule

[rtl/core/irt_res_fifo.sv]
// Result queue of the INI record tokenizer: takes up to two results a cycle,
// hands out one per transfer. Depends on irt_pkg.
module irt_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  irt_pkg::irt_push_t push,
	input  irt_pkg::irt_res_t  rec_res,
	input  irt_pkg::irt_res_t  end_res,
	output logic               room,
	output logic               res_valid,
	input  logic               res_ready,
	output irt_pkg::irt_res_t  res_item
);

	localparam int unsigned DEPTH = irt_pkg::RES_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned NW    = $clog2(DEPTH + 1);

	irt_pkg::irt_res_t mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [NW-1:0]     count_q;

	logic              wr0_en, wr1_en, pop;
	irt_pkg::irt_res_t wr0;
	logic [NW-1:0]     n_push;

	// compact the pushes so the record goes ahead of the end result
	always_comb begin
		wr0_en = push.rec | push.fin;
		wr1_en = push.rec & push.fin;
		wr0    = push.rec ? rec_res : end_res;
		n_push = NW'(wr0_en) + NW'(wr1_en);
		pop    = res_valid & res_ready;
	end

	assign room      = (count_q <= NW'(DEPTH - 2));
	assign res_valid = (count_q != '0);
	assign res_item  = mem_q[rp_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr0_en)
			mem_q[wp_q] <= wr0;
		if (wr1_en)
			mem_q[wp_q + AW'(1)] <= end_res;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(n_push);
			rp_q    <= rp_q + AW'(pop);
			count_q <= count_q + n_push - NW'(pop);
		end
	end

endmodule

[verif/ini_record_tokenizer_tb.sv]
// Self-checking testbench for ini_record_tokenizer: drives source bytes and checks
// every record against a cycle-free scanner model kept in the bench.
// Depends on irt_pkg and the ini_record_tokenizer RTL.
module ini_record_tokenizer_tb;

	localparam int unsigned     CYCLE_LIMIT  = 1000000;
	localparam int unsigned     HOLD_CYCLES  = 300;
	localparam int unsigned     DRAIN_CYCLES = 20;
	localparam int unsigned     RANDOM_BYTES = 1210;
	localparam longint unsigned POS_LIMIT    = (64'd1 << irt_pkg::POSITION_BITS_DEF) - 1;

	// Character codes not in the package
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_RETURN   = 8'h0D;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_ALL_ONES = 8'hFF;

	typedef enum logic [3:0] {
		SCAN_BETWEEN, SCAN_SECT_FIRST, SCAN_SECT_NAME, SCAN_COMMENT,
		SCAN_KEY, SCAN_KEY_ESC, SCAN_VALUE_SKIP, SCAN_VALUE
	} scan_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              src_valid = 1'b0;
	logic              src_ready;
	irt_pkg::irt_src_t src_item  = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	irt_pkg::irt_res_t res_item;

	// Scanner model state
	scan_mode_t      scan_state;
	longint unsigned cur_pos, cur_line, rec_start, key_len, val_start, last_solid;
	bit              sat_seen;
	int unsigned     step_records;

	irt_pkg::irt_res_t pending_records[$];
	logic [7:0]  text_buf[$];
	bit          src_idle_on = 1'b1;
	bit          res_idle_on = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned fail_count = 0;
	int unsigned mismatch_reports = 0;
	int unsigned records_checked = 0;
	int unsigned bytes_sent = 0;
	int unsigned sources_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned kind_tally[5] = '{0, 0, 0, 0, 0};

	ini_record_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- scanner model

	function automatic void reset_scanner();
		scan_state = SCAN_BETWEEN;
		cur_pos    = 0;
		cur_line   = 1;
		rec_start  = 0;
		key_len    = 0;
		val_start  = 0;
		last_solid = 0;
		sat_seen   = 1'b0;
	endfunction

	function automatic longint unsigned advance_pos(longint unsigned p);
		if (p >= POS_LIMIT) begin
			sat_seen = 1'b1;
			return POS_LIMIT;
		end
		return p + 1;
	endfunction

	function automatic logic [15:0] clip_field(longint unsigned v);
		if (v > 64'hFFFF) begin
			sat_seen = 1'b1;
			return irt_pkg::FIELD_MAX;
		end
		return v[15:0];
	endfunction

	// Clamping happens field by field, so the flag reflects any clamp in this record
	function automatic void add_record(irt_pkg::irt_kind_t kind, longint unsigned noff,
			nlen, voff, vlen);
		irt_pkg::irt_res_t r;
		r.record_kind   = kind;
		r.name_offset   = clip_field(noff);
		r.name_length   = clip_field(nlen);
		r.value_offset  = clip_field(voff);
		r.value_length  = clip_field(vlen);
		r.line_number   = cur_line[15:0];
		r.overflow_seen = sat_seen;
		r.run_last      = 1'b0;
		pending_records.push_back(r);
		step_records++;
	endfunction

	function automatic void close_entry(longint unsigned end_pos);
		bit              named;
		longint unsigned len;
		named = (scan_state == SCAN_VALUE_SKIP) || (scan_state == SCAN_VALUE);
		len   = 0;
		if (end_pos > val_start && last_solid >= val_start)
			len = last_solid + 1 - val_start;
		add_record(irt_pkg::KIND_VALUE, named ? rec_start : 0, named ? key_len : 0,
			val_start, len);
		scan_state = SCAN_BETWEEN;
	endfunction

	// Blank skipping and record start detection
	function automatic void skip_between(logic [7:0] b, longint unsigned p);
		if (b <= irt_pkg::CH_SPACE) begin
			if (b == irt_pkg::CH_NEWLINE) begin
				if (cur_line >= irt_pkg::LINE_MAX)
					sat_seen = 1'b1;
				else
					cur_line++;
			end
		end else begin
			rec_start = p;
			if (b == irt_pkg::CH_LBRACKET) begin
				scan_state = SCAN_SECT_FIRST;
			end else if (b == irt_pkg::CH_HASH) begin
				val_start  = advance_pos(p);
				scan_state = SCAN_COMMENT;
			end else begin
				val_start  = p;
				last_solid = p;
				key_len    = 0;
				scan_state = SCAN_KEY;
			end
		end
	endfunction

	function automatic void section_byte(logic [7:0] b, longint unsigned p);
		if (b == irt_pkg::CH_RBRACKET) begin
			add_record(irt_pkg::KIND_SECTION, rec_start, p - rec_start, 0, 0);
			scan_state = SCAN_BETWEEN;
		end else if (b == irt_pkg::CH_NEWLINE) begin
			add_record(irt_pkg::KIND_ERROR, 0, 0, 0, 0);
			scan_state = SCAN_BETWEEN;
			skip_between(b, p);
		end
	endfunction

	// Works out the records one accepted byte gives and queues them
	function automatic void tokenize_byte(logic [7:0] b, bit fin);
		longint unsigned   p, end_pos;
		irt_pkg::irt_res_t tail;
		p            = cur_pos;
		step_records = 0;
		case (scan_state)
			SCAN_SECT_FIRST: begin
				if (b <= irt_pkg::CH_SPACE) begin
					add_record(irt_pkg::KIND_ERROR, 0, 0, 0, 0);
					scan_state = SCAN_BETWEEN;
					skip_between(b, p);
				end else begin
					rec_start  = p;
					scan_state = SCAN_SECT_NAME;
					section_byte(b, p);
				end
			end
			SCAN_SECT_NAME: section_byte(b, p);
			SCAN_COMMENT: begin
				if (b == irt_pkg::CH_NEWLINE) begin
					add_record(irt_pkg::KIND_COMMENT, 0, 0, val_start,
						p > val_start ? p - val_start : 0);
					scan_state = SCAN_BETWEEN;
					skip_between(b, p);
				end
			end
			SCAN_KEY: begin
				if (b == irt_pkg::CH_NEWLINE) begin
					close_entry(p);
					skip_between(b, p);
				end else if (b == irt_pkg::CH_BSLASH) begin
					last_solid = p;
					scan_state = SCAN_KEY_ESC;
				end else if (b == irt_pkg::CH_EQUALS || b == irt_pkg::CH_COLON) begin
					key_len    = last_solid + 1 - rec_start;
					scan_state = SCAN_VALUE_SKIP;
				end else if (b > irt_pkg::CH_SPACE) begin
					last_solid = p;
				end
			end
			SCAN_KEY_ESC: begin
				if (b > irt_pkg::CH_SPACE)
					last_solid = p;
				scan_state = SCAN_KEY;
			end
			SCAN_VALUE_SKIP: begin
				if (b != irt_pkg::CH_SPACE && b != irt_pkg::CH_TAB) begin
					val_start  = p;
					last_solid = p;
					scan_state = SCAN_VALUE;
					if (b == irt_pkg::CH_NEWLINE) begin
						close_entry(p);
						skip_between(b, p);
					end
				end
			end
			SCAN_VALUE: begin
				if (b == irt_pkg::CH_NEWLINE) begin
					close_entry(p);
					skip_between(b, p);
				end else if (b > irt_pkg::CH_SPACE) begin
					last_solid = p;
				end
			end
			default: begin
				scan_state = SCAN_BETWEEN;
				skip_between(b, p);
			end
		endcase

		// End of source: close any open record, add END, start afresh
		if (fin) begin
			end_pos = advance_pos(p);
			case (scan_state)
				SCAN_SECT_FIRST, SCAN_SECT_NAME:
					add_record(irt_pkg::KIND_ERROR, 0, 0, 0, 0);
				SCAN_COMMENT:
					add_record(irt_pkg::KIND_COMMENT, 0, 0, val_start,
						end_pos > val_start ? end_pos - val_start : 0);
				SCAN_VALUE_SKIP: begin
					val_start = end_pos;
					close_entry(end_pos);
				end
				SCAN_KEY, SCAN_KEY_ESC, SCAN_VALUE: close_entry(end_pos);
				default: ;
			endcase
			add_record(irt_pkg::KIND_END, 0, 0, 0, 0);
			reset_scanner();
		end else begin
			cur_pos = advance_pos(p);
		end

		if (step_records > 0) begin
			tail          = pending_records.pop_back();
			tail.run_last = 1'b1;
			pending_records.push_back(tail);
		end
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void report_field(string field, longint unsigned want,
			longint unsigned got);
		fail_count++;
		if (mismatch_reports < 10) begin
			mismatch_reports++;
			$display("mismatch on record %0d: %s expected %0d, got %0d",
				records_checked, field, want, got);
		end
	endfunction

	function automatic void check_result(irt_pkg::irt_res_t got);
		irt_pkg::irt_res_t want;
		if (pending_records.size() == 0) begin
			fail_count++;
			if (mismatch_reports < 10) begin
				mismatch_reports++;
				$display("unexpected record: kind %0d line %0d", got.record_kind,
					got.line_number);
			end
		end else begin
			want = pending_records.pop_front();
			if (got.record_kind !== want.record_kind)
				report_field("record_kind", want.record_kind, got.record_kind);
			if (got.name_offset !== want.name_offset)
				report_field("name_offset", want.name_offset, got.name_offset);
			if (got.name_length !== want.name_length)
				report_field("name_length", want.name_length, got.name_length);
			if (got.value_offset !== want.value_offset)
				report_field("value_offset", want.value_offset, got.value_offset);
			if (got.value_length !== want.value_length)
				report_field("value_length", want.value_length, got.value_length);
			if (got.line_number !== want.line_number)
				report_field("line_number", want.line_number, got.line_number);
			if (got.overflow_seen !== want.overflow_seen)
				report_field("overflow_seen", want.overflow_seen, got.overflow_seen);
			if (got.run_last !== want.run_last)
				report_field("run_last", want.run_last, got.run_last);
			if (want.record_kind <= irt_pkg::KIND_END)
				kind_tally[want.record_kind]++;
			records_checked++;
		end
	endfunction

	// Result transfers are sampled at the edge that completes them
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res_item);
	end

	// Mostly short gaps, the odd long one
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int unsigned stall;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				stall = res_idle_on ? idle_gap() : 0;
				if (stall != 0) begin
					res_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					res_ready <= 1'b1;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d records outstanding", pending_records.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- source side

	// One byte transfer; valid is left high when no gap follows
	task automatic send_byte(input logic [7:0] b, input bit fin);
		irt_pkg::irt_src_t item;
		int unsigned       gap;
		item.source_byte = b;
		item.is_final    = fin;
		src_valid <= 1'b1;
		src_item  <= item;
		do
			@(posedge clk);
		while (!src_ready);
		tokenize_byte(b, fin);
		bytes_sent++;
		gap = src_idle_on ? idle_gap() : 0;
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit ends_source);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], ends_source && (i == s.len() - 1));
		if (ends_source)
			sources_sent++;
	endtask

	task automatic send_source();
		int i;
		for (i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
		sources_sent++;
	endtask

	// Sender pauses until every queued record has been checked
	task automatic wait_for_results();
		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_records.size() != 0);
	endtask

	// ---------------------------------------------------------------- source text

	function automatic void put(logic [7:0] c);
		text_buf.push_back(c);
	endfunction

	function automatic logic [7:0] letter();
		return CH_LOWER_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic void put_word(int unsigned lo, int unsigned hi);
		int unsigned n;
		n = $urandom_range(lo, hi);
		repeat (n) put(letter());
	endfunction

	function automatic void put_blank();
		put($urandom_range(0, 1) ? irt_pkg::CH_SPACE : irt_pkg::CH_TAB);
	endfunction

	function automatic logic [7:0] text_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return letter();
		if (r < 72) return irt_pkg::CH_SPACE;
		if (r < 76) return irt_pkg::CH_TAB;
		if (r < 80) return irt_pkg::CH_EQUALS;
		if (r < 84) return irt_pkg::CH_COLON;
		if (r < 88) return irt_pkg::CH_HASH;
		if (r < 91) return irt_pkg::CH_LBRACKET;
		if (r < 94) return irt_pkg::CH_RBRACKET;
		if (r < 97) return irt_pkg::CH_BSLASH;
		return 8'($urandom_range(33, 126));
	endfunction

	// Blanks between records, newlines and control bytes among them
	function automatic void put_gap_blanks();
		int unsigned n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0: put(irt_pkg::CH_SPACE);
				1: put(irt_pkg::CH_TAB);
				2: put(irt_pkg::CH_NEWLINE);
				3: put(CH_RETURN);
				default: put(CH_NUL);
			endcase
		end
	endfunction

	// name [blanks] = or : [blanks] value [blanks], escapes in the name
	function automatic void put_entry();
		int unsigned n, r;
		put(letter());
		n = $urandom_range(0, 5);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				put(letter());
			end else if (r < 8) begin
				put(irt_pkg::CH_SPACE);
			end else begin
				put(irt_pkg::CH_BSLASH);
				case ($urandom_range(0, 4))
					0: put(irt_pkg::CH_EQUALS);
					1: put(irt_pkg::CH_COLON);
					2: put(irt_pkg::CH_NEWLINE);
					3: put(irt_pkg::CH_BSLASH);
					default: put(letter());
				endcase
			end
		end
		n = $urandom_range(0, 2);
		repeat (n) put_blank();
		put($urandom_range(0, 1) ? irt_pkg::CH_EQUALS : irt_pkg::CH_COLON);
		n = $urandom_range(0, 2);
		repeat (n) put_blank();
		n = $urandom_range(0, 8);
		repeat (n) put(text_char());
		n = $urandom_range(0, 2);
		repeat (n) put_blank();
	endfunction

	function automatic void build_random_source();
		int unsigned count, kind, n;
		text_buf.delete();
		count = $urandom_range(1, 6);
		repeat (count) begin
			if ($urandom_range(0, 4) == 0)
				put_gap_blanks();
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				put(irt_pkg::CH_LBRACKET);
				put_word(1, 6);
				put(irt_pkg::CH_RBRACKET);
			end else if (kind < 32) begin
				put(irt_pkg::CH_HASH);
				n = $urandom_range(0, 10);
				repeat (n) put(text_char());
			end else if (kind < 72) begin
				put_entry();
			end else if (kind < 77) begin
				put_word(1, 5);
			end else if (kind < 84) begin
				// broken section: blank after the bracket, or no closing bracket
				put(irt_pkg::CH_LBRACKET);
				if ($urandom_range(0, 1))
					put(irt_pkg::CH_SPACE);
				else
					put_word(1, 4);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) put(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 6) != 0)
				put(irt_pkg::CH_NEWLINE);
			else
				put(irt_pkg::CH_SPACE);
		end
		// leave the last record open at the end of source now and then
		if ($urandom_range(0, 2) == 0)
			void'(text_buf.pop_back());
		if (text_buf.size() == 0)
			put(irt_pkg::CH_NEWLINE);
	endfunction

	// ---------------------------------------------------------------- tests

	// Section, comment, escaped separator, colon split, empty value, unnamed entry
	task automatic test_record_kinds();
		send_text("[s]#c\nk\\=:v\t\nx=\nu", 1'b1);
	endtask

	// Blank after '[', section cut by newline, section cut by end of source
	task automatic test_syntax_errors();
		send_text("[ [ab\n[c", 1'b1);
	endtask

	// Byte extremes, escaped newline, lone final newline, comment cut by end
	task automatic test_edge_bytes();
		send_byte(CH_NUL, 1'b0);
		send_text("a\\\nb", 1'b0);
		send_byte(CH_ALL_ONES, 1'b1);
		sources_sent++;
		send_text("\n", 1'b1);
		send_text("#x", 1'b1);
	endtask

	// Long result hold-off while sections keep coming: the block must stall its input
	task automatic test_result_backpressure();
		text_buf.delete();
		repeat (24) begin
			put(irt_pkg::CH_LBRACKET);
			put(letter());
			put(irt_pkg::CH_RBRACKET);
		end
		put(irt_pkg::CH_NEWLINE);
		src_idle_on  = 1'b0;
		hold_request = 1'b1;
		send_source();
		wait_for_results();
		src_idle_on = 1'b1;
	endtask

	task automatic test_random_sources();
		int unsigned random_bytes;
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			if (sources_sent % 6 == 0) begin
				src_idle_on = $urandom_range(0, 3) != 0;
				res_idle_on = $urandom_range(0, 3) != 0;
			end
			build_random_source();
			random_bytes += text_buf.size();
			send_source();
			if ($urandom_range(0, 4) == 0)
				wait_for_results();
		end
		src_idle_on = 1'b1;
		res_idle_on = 1'b1;
		wait_for_results();
	endtask

	initial begin
		reset_scanner();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_record_kinds();
		test_syntax_errors();
		test_edge_bytes();
		wait_for_results();
		test_result_backpressure();
		test_random_sources();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d sources, %0d bytes and %0d records", sources_sent,
			bytes_sent, records_checked);
		$display("sections %0d, comments %0d, entries %0d, syntax errors %0d, ends %0d",
			kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4]);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/irt_pkg.sv
rtl/core/irt_scan.sv
rtl/core/irt_res_fifo.sv
rtl/core/ini_record_tokenizer.sv
verif/ini_record_tokenizer_tb.sv
